[rtl/core/ncf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ncf_pkg;

    // fixed-point position format
    localparam int FRAC_BITS    = 16;

    // quantisation scales of the cone axis and the spread factor
    localparam int AXIS_SCALE   = 32766;
    localparam int SPREAD_SCALE = 3276;
    localparam int GATE_DEN     = 1000;   // f must reach 1/GATE_DEN

    // widths of the words passed to the compare unit
    localparam int G_W          = 81;     // scaled facing value, signed
    localparam int S_W          = 97;     // sum of squared offsets, unsigned
    localparam int SCALE_SQ_W   = 54;

    // smallest scaled value that passes the threshold: ceil(Ka^2*Ks*2^F / 1000)
    localparam logic [127:0] FACE_NUM =
        (128'(AXIS_SCALE) * 128'(AXIS_SCALE) * 128'(SPREAD_SCALE)) << FRAC_BITS;
    localparam logic [127:0] FACE_CEIL =
        (FACE_NUM + 128'(GATE_DEN - 1)) / 128'(GATE_DEN);
    localparam logic signed [G_W-1:0] FACE_MIN = $signed(FACE_CEIL[G_W-1:0]);

    // (Ka*Ks)^2, weight of the squared offset length
    localparam logic [63:0]  SCALE_PROD    = 64'(AXIS_SCALE) * 64'(SPREAD_SCALE);
    localparam logic [127:0] SCALE_SQ_FULL = 128'(SCALE_PROD) * 128'(SCALE_PROD);
    localparam logic [SCALE_SQ_W-1:0] SCALE_SQ = SCALE_SQ_FULL[SCALE_SQ_W-1:0];

    typedef struct packed {
        logic [G_W-1:0] g;    // two's complement
        logic [S_W-1:0] s;
    } t_cmp_word;

endpackage

`default_nettype wire

[rtl/core/ncf_face_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none

module ncf_face_cmp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire ncf_pkg::t_cmp_word i_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_facing
);

    localparam int NSTG   = 4;
    localparam int LIMB_W = 27;
    localparam int SL_W   = 32;
    localparam int PP_W   = 2 * LIMB_W;
    localparam int PS_W   = 33 + LIMB_W;
    localparam int WIDE_W = 160;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: threshold test and limb products
    logic [ncf_pkg::G_W-2:0] w_gm;
    logic [LIMB_W-1:0]       w_g0, w_g1;
    logic [ncf_pkg::G_W-2-2*LIMB_W:0] w_g2;
    logic [SL_W-1:0]         w_s0, w_s1;
    logic [ncf_pkg::S_W-2*SL_W-1:0] w_s2;
    logic [LIMB_W-1:0]       w_h0, w_h1;
    logic                    n_pass;
    logic [PP_W-1:0]         n_pp [6];
    logic [PS_W-1:0]         n_ps [6];

    // the square only matters once g has passed the threshold, so g is positive there
    assign w_gm = i_word.g[ncf_pkg::G_W-2:0];
    assign w_g0 = w_gm[LIMB_W-1:0];
    assign w_g1 = w_gm[2*LIMB_W-1:LIMB_W];
    assign w_g2 = w_gm[ncf_pkg::G_W-2:2*LIMB_W];
    assign w_s0 = i_word.s[SL_W-1:0];
    assign w_s1 = i_word.s[2*SL_W-1:SL_W];
    assign w_s2 = i_word.s[ncf_pkg::S_W-1:2*SL_W];
    assign w_h0 = ncf_pkg::SCALE_SQ[LIMB_W-1:0];
    assign w_h1 = ncf_pkg::SCALE_SQ[2*LIMB_W-1:LIMB_W];

    always_comb begin
        n_pass  = $signed(i_word.g) >= ncf_pkg::FACE_MIN;
        n_pp[0] = w_g0 * w_g0;
        n_pp[1] = w_g0 * w_g1;
        n_pp[2] = w_g0 * w_g2;
        n_pp[3] = w_g1 * w_g1;
        n_pp[4] = w_g1 * w_g2;
        n_pp[5] = w_g2 * w_g2;
        n_ps[0] = w_s0 * w_h0;
        n_ps[1] = w_s0 * w_h1;
        n_ps[2] = w_s1 * w_h0;
        n_ps[3] = w_s1 * w_h1;
        n_ps[4] = w_s2 * w_h0;
        n_ps[5] = w_s2 * w_h1;
    end

    logic            r_pass1, r_pass2, r_pass3;
    logic [PP_W-1:0] r_pp [6];
    logic [PS_W-1:0] r_ps [6];

    // stage 2: partial sums; cross terms of the square count twice
    logic [WIDE_W-1:0] n_sqa, n_sqb, n_ra, n_rb;

    always_comb begin
        n_sqa = WIDE_W'(r_pp[0])
              + (WIDE_W'(r_pp[1]) << (LIMB_W + 1))
              + (WIDE_W'(r_pp[3]) << (2 * LIMB_W));
        n_sqb = (WIDE_W'(r_pp[2]) << (2 * LIMB_W + 1))
              + (WIDE_W'(r_pp[4]) << (3 * LIMB_W + 1))
              + (WIDE_W'(r_pp[5]) << (4 * LIMB_W));
        n_ra  = WIDE_W'(r_ps[0])
              + (WIDE_W'(r_ps[1]) << LIMB_W)
              + (WIDE_W'(r_ps[2]) << SL_W);
        n_rb  = (WIDE_W'(r_ps[3]) << (SL_W + LIMB_W))
              + (WIDE_W'(r_ps[4]) << (2 * SL_W))
              + (WIDE_W'(r_ps[5]) << (2 * SL_W + LIMB_W));
    end

    logic [WIDE_W-1:0] r_sqa, r_sqb, r_ra, r_rb;
    logic [WIDE_W-1:0] r_sq, r_r;
    logic              r_facing;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pass1 <= n_pass;
            r_pp    <= n_pp;
            r_ps    <= n_ps;
        end
        if (w_en[1]) begin
            r_pass2 <= r_pass1;
            r_sqa   <= n_sqa;
            r_sqb   <= n_sqb;
            r_ra    <= n_ra;
            r_rb    <= n_rb;
        end
        if (w_en[2]) begin
            r_pass3 <= r_pass2;
            r_sq    <= r_sqa + r_sqb;
            r_r     <= r_ra + r_rb;
        end
        if (w_en[3]) begin
            r_facing <= r_pass3 && !(r_sq < r_r);
        end
    end

    assign o_facing = r_facing;

endmodule

`default_nettype wire

[rtl/core/normal_cone_facing_test_unit.sv]
// Normal cone facing test, fully pipelined.
// Throughput: one word per cycle while the output is not stalled; ten register stages,
// six here and four in the compare unit, set the depth.
// Empty stages close up under a stall, so input is taken until every stage is full.
// Synchronous active-low reset clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module normal_cone_facing_test_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_cmd,
    input  wire logic signed [15:0]   i_axis_x,
    input  wire logic signed [15:0]   i_axis_y,
    input  wire logic signed [15:0]   i_axis_z,
    input  wire logic        [14:0]   i_spread,
    input  wire logic signed [31:0]   i_center_x,
    input  wire logic signed [31:0]   i_center_y,
    input  wire logic signed [31:0]   i_center_z,
    input  wire logic        [30:0]   i_radius,
    input  wire logic signed [31:0]   i_eye_x,
    input  wire logic signed [31:0]   i_eye_y,
    input  wire logic signed [31:0]   i_eye_z,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_facing
);

    localparam int NSTG     = 6;
    localparam int LANES    = 3;
    localparam int AXIS_W   = 16;
    localparam int SPREAD_W = 15;
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int AR_W     = 47;
    localparam int D_W      = 49;
    localparam int DA_W     = 64;
    localparam int MAG_W    = 48;
    localparam int HALF_W   = 24;
    localparam int SQ_W     = 96;
    localparam int SDA_W    = 66;
    localparam int LO_W     = 33;
    localparam int GP_W     = 48;
    localparam int G_W      = ncf_pkg::G_W;
    localparam int S_W      = ncf_pkg::S_W;

    localparam logic signed [AXIS_W-1:0] KA_S = AXIS_W'(ncf_pkg::AXIS_SCALE);

    // stage handshake: a stage moves when it is empty or the next one moves
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;
    logic            w_cmp_stall;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || !w_cmp_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: centre minus eye, axis times radius
    logic signed [AXIS_W-1:0]  w_a [LANES];
    logic signed [COORD_W-1:0] w_c [LANES];
    logic signed [COORD_W-1:0] w_e [LANES];
    logic signed [COORD_W-1:0] w_rad;
    logic signed [DIFF_W-1:0]  n_diff [LANES];
    logic signed [AR_W-1:0]    n_ar [LANES];

    assign w_a[0] = i_axis_x;
    assign w_a[1] = i_axis_y;
    assign w_a[2] = i_axis_z;
    assign w_c[0] = i_center_x;
    assign w_c[1] = i_center_y;
    assign w_c[2] = i_center_z;
    assign w_e[0] = i_eye_x;
    assign w_e[1] = i_eye_y;
    assign w_e[2] = i_eye_z;
    assign w_rad  = $signed({1'b0, i_radius});

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_diff[i] = DIFF_W'(w_c[i]) - DIFF_W'(w_e[i]);
            n_ar[i]   = w_a[i] * w_rad;
        end
    end

    logic signed [DIFF_W-1:0] r_diff [LANES];
    logic signed [AR_W-1:0]   r_ar [LANES];
    logic signed [AXIS_W-1:0] r_axis1 [LANES];
    logic signed [AXIS_W-1:0] r_axis2 [LANES];
    logic [SPREAD_W-1:0]      r_spread1, r_spread2, r_spread3, r_spread4;
    logic                     r_cmd1, r_cmd2, r_cmd3, r_cmd4, r_cmd5;

    // stage 2: offset D = Ka*(c - e) +/- a*r, anchor moves toward or away from the eye
    logic signed [D_W-1:0] w_kad [LANES];
    logic signed [D_W-1:0] n_d [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_kad[i] = r_diff[i] * KA_S;
            n_d[i]   = w_kad[i] + (r_cmd1 ? -D_W'(r_ar[i]) : D_W'(r_ar[i]));
        end
    end

    logic signed [D_W-1:0] r_d [LANES];

    // stage 3: D*a and the square of |D| from 24-bit halves
    logic signed [DA_W-1:0] n_p [LANES];
    logic signed [D_W-1:0]  w_dabs [LANES];
    logic [MAG_W-1:0]       w_mag [LANES];
    logic [MAG_W-1:0]       n_qhh [LANES];
    logic [MAG_W-1:0]       n_qhl [LANES];
    logic [MAG_W-1:0]       n_qll [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_p[i]    = r_d[i] * r_axis2[i];
            w_dabs[i] = r_d[i][D_W-1] ? -r_d[i] : r_d[i];
            w_mag[i]  = w_dabs[i][MAG_W-1:0];
            n_qhh[i]  = w_mag[i][MAG_W-1:HALF_W] * w_mag[i][MAG_W-1:HALF_W];
            n_qhl[i]  = w_mag[i][MAG_W-1:HALF_W] * w_mag[i][HALF_W-1:0];
            n_qll[i]  = w_mag[i][HALF_W-1:0] * w_mag[i][HALF_W-1:0];
        end
    end

    logic signed [DA_W-1:0] r_p [LANES];
    logic [MAG_W-1:0]       r_qhh [LANES];
    logic [MAG_W-1:0]       r_qhl [LANES];
    logic [MAG_W-1:0]       r_qll [LANES];

    // stage 4: dot product and per-lane squares
    logic signed [SDA_W-1:0] n_sda;
    logic [SQ_W-1:0]         n_q [LANES];

    always_comb begin
        n_sda = SDA_W'(r_p[0]) + SDA_W'(r_p[1]) + SDA_W'(r_p[2]);
        for (int i = 0; i < LANES; i++) begin
            n_q[i] = {r_qhh[i], {MAG_W{1'b0}}}
                   + {{(SQ_W-MAG_W-HALF_W-1){1'b0}}, r_qhl[i], {(HALF_W+1){1'b0}}}
                   + {{MAG_W{1'b0}}, r_qll[i]};
        end
    end

    logic signed [SDA_W-1:0] r_sda;
    logic [SQ_W-1:0]         r_q [LANES];

    // stage 5: length sum, spread times dot product in two halves
    logic [S_W-1:0]         n_s;
    logic [GP_W-1:0]        n_gl;
    logic signed [GP_W-1:0] n_gh;

    always_comb begin
        n_s  = S_W'(r_q[0]) + S_W'(r_q[1]) + S_W'(r_q[2]);
        n_gl = r_sda[LO_W-1:0] * r_spread4;
        n_gh = $signed(r_sda[SDA_W-1:LO_W]) * $signed({1'b0, r_spread4});
    end

    logic [S_W-1:0]         r_s;
    logic [GP_W-1:0]        r_gl;
    logic signed [GP_W-1:0] r_gh;

    // stage 6: join the halves, flip the sign for the front test
    logic signed [G_W-1:0] w_gsum;
    ncf_pkg::t_cmp_word    n_word;

    always_comb begin
        w_gsum   = $signed({r_gh, {LO_W{1'b0}}}) + $signed({{(G_W-GP_W){1'b0}}, r_gl});
        n_word.g = r_cmd5 ? -w_gsum : w_gsum;
        n_word.s = r_s;
    end

    ncf_pkg::t_cmp_word r_word;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_diff    <= n_diff;
            r_ar      <= n_ar;
            r_axis1   <= w_a;
            r_spread1 <= i_spread;
            r_cmd1    <= i_cmd;
        end
        if (w_en[1]) begin
            r_d       <= n_d;
            r_axis2   <= r_axis1;
            r_spread2 <= r_spread1;
            r_cmd2    <= r_cmd1;
        end
        if (w_en[2]) begin
            r_p       <= n_p;
            r_qhh     <= n_qhh;
            r_qhl     <= n_qhl;
            r_qll     <= n_qll;
            r_spread3 <= r_spread2;
            r_cmd3    <= r_cmd2;
        end
        if (w_en[3]) begin
            r_sda     <= n_sda;
            r_q       <= n_q;
            r_spread4 <= r_spread3;
            r_cmd4    <= r_cmd3;
        end
        if (w_en[4]) begin
            r_s       <= n_s;
            r_gl      <= n_gl;
            r_gh      <= n_gh;
            r_cmd5    <= r_cmd4;
        end
        if (w_en[5]) begin
            r_word    <= n_word;
        end
    end

    ncf_face_cmp u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v[NSTG-1]),
        .o_stall  (w_cmp_stall),
        .i_word   (r_word),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_facing (o_facing)
    );

    // input is held off only when every stage holds a word and the output is blocked
    ap_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_v) && i_stall))
        else $error("input stalled with a free stage");

    // result word holds while the receiver stalls
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_facing)))
        else $error("result word changed under stall");

    // the last stage keeps its word while the compare unit is blocked
    ap_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-1] && w_cmp_stall) |=> (r_v[NSTG-1] && $stable(r_word)))
        else $error("tail word lost under stall");

endmodule

`default_nettype wire

[tb/sv/normal_cone_facing_test_unit_tb.sv]
`timescale 1ns / 1ps

module normal_cone_facing_test_unit_tb;

    import ncf_pkg::*;

    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int SMALL_SPAN = 1 << 20;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 20;   // idle wait before the final check for outstanding words
    localparam int N_PHASES   = 4;
    localparam int PHASE_WORDS = 100;

    typedef struct {
        logic               cmd;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic        [14:0] spread;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] radius;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
    } cone_word_t;

    class facing_scoreboard;
        bit facing_q[$];
        int n_errors = 0;

        // exact integer form of the cone test, all terms at 256 bits
        function automatic bit facing_of(cone_word_t w);
            logic signed [255:0] sum_da, sum_d2, g, dv, av, sp, ka, ks, gate, thr;
            longint axv[3], ctr[3], eye[3];
            longint sgn, dd;
            axv[0] = longint'(w.axis_x);   axv[1] = longint'(w.axis_y);
            axv[2] = longint'(w.axis_z);
            ctr[0] = longint'(w.center_x); ctr[1] = longint'(w.center_y);
            ctr[2] = longint'(w.center_z);
            eye[0] = longint'(w.eye_x);    eye[1] = longint'(w.eye_y);
            eye[2] = longint'(w.eye_z);
            sgn = w.cmd ? -64'sd1 : 64'sd1;
            sum_da = '0;
            sum_d2 = '0;
            for (int i = 0; i < 3; i++) begin
                dd = longint'(AXIS_SCALE) * (ctr[i] - eye[i])
                   + sgn * axv[i] * longint'(w.radius);
                dv = 256'(dd);
                av = 256'(axv[i]);
                sum_da = sum_da + dv * av;
                sum_d2 = sum_d2 + dv * dv;
            end
            sp   = 256'(w.spread);
            ka   = 256'(AXIS_SCALE);
            ks   = 256'(SPREAD_SCALE);
            gate = 256'(GATE_DEN);
            g = sum_da * sp;
            if (w.cmd)
                g = -g;
            thr = (ka * ka * ks) <<< FRAC_BITS;
            return !((gate * g < thr) || (g * g < sum_d2 * ka * ka * ks * ks));
        endfunction

        function void note_word(cone_word_t w);
            facing_q.push_back(facing_of(w));
        endfunction

        task report(string msg);
            n_errors++;
            $display("mismatch %0d at %0t: %s", n_errors, $realtime, msg);
        endtask

        task check_facing(logic got);
            bit want;
            if (facing_q.size() == 0) begin
                report("result word with nothing outstanding");
            end else begin
                want = facing_q.pop_front();
                if (got !== want)
                    report($sformatf("facing got %b want %b", got, want));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic i_stall;
    logic o_stall;
    logic o_valid;
    logic o_facing;

    cone_word_t tx;
    facing_scoreboard sb = new;

    int  sender_idle_pct;
    int  stall_pct;
    bit  hold_req;
    int  hold_left;

    wire               i_cmd      = tx.cmd;
    wire signed [15:0] i_axis_x   = tx.axis_x;
    wire signed [15:0] i_axis_y   = tx.axis_y;
    wire signed [15:0] i_axis_z   = tx.axis_z;
    wire        [14:0] i_spread   = tx.spread;
    wire signed [31:0] i_center_x = tx.center_x;
    wire signed [31:0] i_center_y = tx.center_y;
    wire signed [31:0] i_center_z = tx.center_z;
    wire        [30:0] i_radius   = tx.radius;
    wire signed [31:0] i_eye_x    = tx.eye_x;
    wire signed [31:0] i_eye_y    = tx.eye_y;
    wire signed [31:0] i_eye_z    = tx.eye_z;

    normal_cone_facing_test_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_axis_x   (i_axis_x),
        .i_axis_y   (i_axis_y),
        .i_axis_z   (i_axis_z),
        .i_spread   (i_spread),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_center_z (i_center_z),
        .i_radius   (i_radius),
        .i_eye_x    (i_eye_x),
        .i_eye_y    (i_eye_y),
        .i_eye_z    (i_eye_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_facing   (o_facing)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_word(tx);
            if (o_valid && !i_stall)
                sb.check_facing(o_facing);
        end
    end

    // receiver: random stall, or a long hold-off counted here
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic cone_word_t make_word(bit cmd, int ax, int ay, int az, int sp,
                                             int cx, int cy, int cz, int r,
                                             int ex, int ey, int ez);
        cone_word_t w;
        w.cmd      = cmd;
        w.axis_x   = ax[15:0];
        w.axis_y   = ay[15:0];
        w.axis_z   = az[15:0];
        w.spread   = sp[14:0];
        w.center_x = cx;
        w.center_y = cy;
        w.center_z = cz;
        w.radius   = r[30:0];
        w.eye_x    = ex;
        w.eye_y    = ey;
        w.eye_z    = ez;
        return w;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(99) < 30)
            return $urandom;
        return int'($urandom_range(2 * SMALL_SPAN)) - SMALL_SPAN;
    endfunction

    function automatic logic signed [15:0] rand_axis();
        if ($urandom_range(99) < 25)
            return 16'($urandom);
        return 16'(int'($urandom_range(2 * AXIS_SCALE)) - AXIS_SCALE);
    endfunction

    function automatic cone_word_t rand_word();
        cone_word_t w;
        w.cmd    = 1'($urandom_range(1));
        w.axis_x = rand_axis();
        w.axis_y = rand_axis();
        w.axis_z = rand_axis();
        w.spread = ($urandom_range(99) < 20) ? 15'($urandom) : 15'($urandom_range(32760));
        w.radius = ($urandom_range(99) < 30) ? 31'($urandom)
                                             : 31'($urandom_range(SMALL_SPAN));
        w.center_x = rand_coord();
        w.center_y = rand_coord();
        w.center_z = rand_coord();
        w.eye_x    = rand_coord();
        w.eye_y    = rand_coord();
        w.eye_z    = rand_coord();
        return w;
    endfunction

    // called just after an accepting edge (or after reset); returns on acceptance
    task drive_word(cone_word_t w);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        tx      <= w;
        i_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    task wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.facing_q.size() != 0)
            @(negedge i_clk);
    endtask

    int idle_tab[N_PHASES]  = '{0, 73, 0, 10};
    int stall_tab[N_PHASES] = '{0, 0, 73, 10};
    cone_word_t directed[$];

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        tx        = make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        sender_idle_pct = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        hold_left = 0;

        // f exactly equal to |d|: passes
        directed.push_back(make_word(0, AXIS_SCALE, 0, 0, SPREAD_SCALE,
                                     10 * ONE_Q, 0, 0, 0, 0, 0, 0));
        // spread just under one: fails the length test
        directed.push_back(make_word(0, AXIS_SCALE, 0, 0, SPREAD_SCALE - 1,
                                     10 * ONE_Q, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(1, -AXIS_SCALE, 0, 0, SPREAD_SCALE,
                                     10 * ONE_Q, 0, 0, 0, 0, 0, 0));
        // zero spread, zero axis
        directed.push_back(make_word(0, AXIS_SCALE, 0, 0, 0, 10 * ONE_Q, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(1, 0, 0, 0, 32760, 10 * ONE_Q, 0, 0, 0, 0, 0, 0));
        // axis of -32768 and spread above ten, with extreme positions
        directed.push_back(make_word(0, -32768, -32768, -32768, 32767,
                                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                     32'h7fff_ffff));
        directed.push_back(make_word(1, 32767, 32767, 32767, 32767,
                                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                     32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                     32'h8000_0000));
        directed.push_back(make_word(0, -AXIS_SCALE, AXIS_SCALE, -AXIS_SCALE, 32760,
                                     -ONE_Q, ONE_Q, -ONE_Q, 0, 0, 0, 0));
        // about the 0.001 gate: f roughly ten times above it, then well below
        directed.push_back(make_word(0, AXIS_SCALE, 0, 0, 32760, 65, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(0, AXIS_SCALE, 0, 0, 32760, 1, 0, 0, 0, 0, 0, 0));
        // eye on the anchor point: d is zero
        directed.push_back(make_word(0, 0, AXIS_SCALE, 0, SPREAD_SCALE,
                                     0, 0, 0, ONE_Q, 0, ONE_Q, 0));
        // radius pushes the anchor along the axis
        directed.push_back(make_word(0, 0, AXIS_SCALE, 0, SPREAD_SCALE,
                                     0, 0, 0, 5 * ONE_Q, 0, -ONE_Q, 0));
        directed.push_back(make_word(1, 0, 0, -AXIS_SCALE, SPREAD_SCALE,
                                     0, 0, 0, 5 * ONE_Q, 0, 0, -ONE_Q));
        directed.push_back(make_word(1, -32768, 0, 32767, 1, -1, -1, -1,
                                     32'h7fff_ffff, 0, 0, 0));
        directed.push_back(make_word(0, 23170, 23170, 0, 32767, ONE_Q, ONE_Q, 0,
                                     0, 0, 0, 0));
        directed.push_back(make_word(1, 23170, 23170, 0, 32767, -ONE_Q, -ONE_Q, 0,
                                     ONE_Q, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k])
            drive_word(directed[k]);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            sender_idle_pct = idle_tab[p];
            stall_pct       = stall_tab[p];
            // long hold-off while words keep coming, so the pipe backs up
            if (p == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                drive_word(rand_word());
            wait_drained();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.facing_q.size() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.facing_q.size()));

        if (sb.n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
